@@ rtl/fracture_detach_and_collapse_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the fracture detach and collapse block
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef FRACTURE_DETACH_AND_COLLAPSE_MACROS_SVH
`define FRACTURE_DETACH_AND_COLLAPSE_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define FDC_CHECK(name, prop) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fdc: check failed");

// Same, with a message of the caller's choice.
`define FDC_CHECK_MSG(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`endif

@@ rtl/fdc_pkg.sv @@
// ----------------------------------------------------------------------------
// fdc_pkg
// Constants and codes shared by the fracture detach and collapse block.
// ----------------------------------------------------------------------------
package fdc_pkg;

	localparam int NUM_CHUNKS = 64;
	localparam int IDX_W      = $clog2(NUM_CHUNKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int COORD_BITS = 16;
	localparam int VAL_W      = 16;

	localparam logic [2:0] FUNC_LOAD_CHUNK = 3'd0;
	localparam logic [2:0] FUNC_LOAD_EDGE  = 3'd1;
	localparam logic [2:0] FUNC_CHIP_HIT   = 3'd2;
	localparam logic [2:0] FUNC_DIRECT_HIT = 3'd3;
	localparam logic [2:0] FUNC_RESTORE    = 3'd4;

	localparam logic [1:0] EV_DAMAGE   = 2'd0;
	localparam logic [1:0] EV_DETACHED = 2'd1;
	localparam logic [1:0] EV_COLLAPSE = 2'd2;
	localparam logic [1:0] EV_NOTHING  = 2'd3;

	localparam logic [1:0] REG_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_RADIUS    = 2'd1;
	localparam logic [1:0] REG_COUNT     = 2'd2;

	localparam logic [VAL_W-1:0] THRESHOLD_RESET = 16'd25600;
	localparam logic [VAL_W-1:0] RADIUS_RESET    = 16'd512;

endpackage

@@ rtl/fracture_detach_and_collapse.sv @@
// ----------------------------------------------------------------------------
// fracture_detach_and_collapse
// Chunk store with hit search, damage accumulation, radius flood fill and
// anchor support walk, all run by one sequencer around a shared multiplier.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake                       Beat
// command   in         start high while busy low       func, indices, position, damage
// result    out        valid high for one cycle        event_kind, chunk_id, damage_total, is_seed, last
// config    in         psel, penable, pwrite, pready   paddr, pwdata, prdata
//
// A load or restore is done in the cycle it is accepted; an edge load passes
// through a wait state and a write state. A hit runs the nearest search over
// the intact chunks, then each walk scans every chunk and adjacency bit, and
// the flood fill also computes a distance for each candidate. The adjacency row read and the
// single multiplier set the pace. Reset clears all control state and flags.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module fracture_detach_and_collapse
	import fdc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            func,
	input  logic [IDX_W-1:0]      chunk_index,
	input  logic [IDX_W-1:0]      neighbor_index,
	input  logic signed [COORD_BITS-1:0] pos_x,
	input  logic signed [COORD_BITS-1:0] pos_y,
	input  logic signed [COORD_BITS-1:0] pos_z,
	input  logic                  anchored,
	input  logic [VAL_W-1:0]      damage_amount,
	input  logic [VAL_W-1:0]      damage_radius,
	output logic                  valid,
	output logic [1:0]            event_kind,
	output logic [IDX_W-1:0]      chunk_id,
	output logic [VAL_W-1:0]      damage_total,
	output logic                  is_seed,
	output logic                  last,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int PW = 2 * COORD_BITS;
	localparam int AW = PW + 2;

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_EWAIT = 5'd1;
	localparam logic [4:0] ST_EWR   = 5'd2;
	localparam logic [4:0] ST_DRD   = 5'd3;
	localparam logic [4:0] ST_DMUL  = 5'd4;
	localparam logic [4:0] ST_NR    = 5'd5;
	localparam logic [4:0] ST_NRCMP = 5'd6;
	localparam logic [4:0] ST_DMGW  = 5'd7;
	localparam logic [4:0] ST_DMG   = 5'd8;
	localparam logic [4:0] ST_R2    = 5'd9;
	localparam logic [4:0] ST_B1    = 5'd10;
	localparam logic [4:0] ST_B2    = 5'd11;
	localparam logic [4:0] ST_BROW  = 5'd12;
	localparam logic [4:0] ST_B3    = 5'd13;
	localparam logic [4:0] ST_B4    = 5'd14;
	localparam logic [4:0] ST_BEND  = 5'd15;
	localparam logic [4:0] ST_A1    = 5'd16;
	localparam logic [4:0] ST_S1    = 5'd17;
	localparam logic [4:0] ST_S2    = 5'd18;
	localparam logic [4:0] ST_SROW  = 5'd19;
	localparam logic [4:0] ST_S3    = 5'd20;
	localparam logic [4:0] ST_CL    = 5'd21;
	localparam logic [4:0] ST_FLUSH = 5'd22;

	logic [VAL_W-1:0] thr_q, rad_cfg_q;
	logic [CNT_W-1:0] count_q, n_used;

	logic [4:0] state_q, ret_q;
	logic [2:0] func_q;
	logic [IDX_W-1:0] ni_q, node_q, seed_q, dist_idx_q;
	logic [COORD_BITS-1:0] px_q, py_q, pz_q;
	logic [VAL_W-1:0] amt_q, hit_rad_q, radius_q;
	logic [PW-1:0] r2_q, prod_q, prod_w;
	logic [AW-1:0] acc_q, best_d_q;
	logic [CNT_W-1:0] c_q, j_q, head_q, tail_q;
	logic [1:0] dk_q;
	logic best_v_q, det_any_q, any_anch_q;
	logic [NUM_CHUNKS-1:0] anchor_q, destroyed_q, visit_q, dmg_v_q, adj_v_q;
	logic pend_v_q, pend_seed_q;
	logic [1:0] pend_kind_q;
	logic [IDX_W-1:0] pend_id_q;
	logic [VAL_W-1:0] pend_total_q;

	logic [3*COORD_BITS-1:0] cent_mem [NUM_CHUNKS];
	logic [NUM_CHUNKS-1:0]   adj_mem  [NUM_CHUNKS];
	logic [VAL_W-1:0]        dmg_mem  [NUM_CHUNKS];
	logic [IDX_W-1:0]        q_mem    [NUM_CHUNKS];
	logic [3*COORD_BITS-1:0] cent_rd_q;
	logic [NUM_CHUNKS-1:0]   adj_rd_q;
	logic [VAL_W-1:0]        dmg_rd_q;
	logic [IDX_W-1:0]        q_rd_q;

	logic accept, cent_we, adj_we, dmg_we, q_we, cand;
	logic [NUM_CHUNKS-1:0] row_w, adj_wdata;
	logic [IDX_W-1:0] q_waddr, q_wdata;
	logic [COORD_BITS-1:0] ca, pb, diff, mul_op;
	logic [VAL_W:0] sum_w;
	logic [VAL_W-1:0] sat_w;
	logic [3*COORD_BITS-1:0] cent_wdata;

	assign pready = 1'b1;
	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign n_used = (count_q > CNT_W'(NUM_CHUNKS)) ? CNT_W'(NUM_CHUNKS) : count_q;

	always_comb begin
		case (paddr[3:2])
			REG_THRESHOLD: prdata = {16'd0, thr_q};
			REG_RADIUS:    prdata = {16'd0, rad_cfg_q};
			REG_COUNT:     prdata = {{(32-CNT_W){1'b0}}, count_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= THRESHOLD_RESET;
			rad_cfg_q <= RADIUS_RESET;
			count_q   <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_THRESHOLD: thr_q     <= pwdata[VAL_W-1:0];
				REG_RADIUS:    rad_cfg_q <= pwdata[VAL_W-1:0];
				REG_COUNT:     count_q   <= pwdata[CNT_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		row_w = adj_v_q[node_q] ? adj_rd_q : '0;
		adj_wdata = row_w | (NUM_CHUNKS'(1) << ni_q);
		cand = row_w[j_q[IDX_W-1:0]] && !visit_q[j_q[IDX_W-1:0]] &&
			!destroyed_q[j_q[IDX_W-1:0]];
		case (dk_q)
			2'd0:    begin ca = cent_rd_q[COORD_BITS-1:0]; pb = px_q; end
			2'd1:    begin ca = cent_rd_q[2*COORD_BITS-1:COORD_BITS]; pb = py_q; end
			default: begin ca = cent_rd_q[3*COORD_BITS-1:2*COORD_BITS]; pb = pz_q; end
		endcase
		diff   = (ca >= pb) ? (ca - pb) : (pb - ca);
		mul_op = (state_q == ST_R2) ? radius_q : diff;
		prod_w = {{COORD_BITS{1'b0}}, mul_op} * {{COORD_BITS{1'b0}}, mul_op};
		sum_w  = {1'b0, (dmg_v_q[seed_q] ? dmg_rd_q : '0)} + {1'b0, amt_q};
		sat_w  = sum_w[VAL_W] ? '1 : sum_w[VAL_W-1:0];
		cent_we = accept && (func == FUNC_LOAD_CHUNK);
		cent_wdata = {pos_z ^ {1'b1, {(COORD_BITS-1){1'b0}}},
			pos_y ^ {1'b1, {(COORD_BITS-1){1'b0}}},
			pos_x ^ {1'b1, {(COORD_BITS-1){1'b0}}}};
		adj_we = (state_q == ST_EWR);
		dmg_we = (state_q == ST_DMG) && (sat_w < thr_q);
		q_we    = 1'b0;
		q_waddr = tail_q[IDX_W-1:0];
		q_wdata = j_q[IDX_W-1:0];
		case (state_q)
			ST_R2: begin
				q_we    = 1'b1;
				q_waddr = '0;
				q_wdata = seed_q;
			end
			ST_B4: q_we = ({2'b0, acc_q[AW-3:0]} == acc_q) && (acc_q[AW-3:0] <= r2_q) &&
				(tail_q < CNT_W'(NUM_CHUNKS));
			ST_A1: begin
				q_we = (c_q != n_used) && !destroyed_q[c_q[IDX_W-1:0]] &&
					anchor_q[c_q[IDX_W-1:0]];
				q_wdata = c_q[IDX_W-1:0];
			end
			ST_S3: q_we = (j_q != n_used) && cand && (tail_q < CNT_W'(NUM_CHUNKS));
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cent_we)
			cent_mem[chunk_index] <= cent_wdata;
		cent_rd_q <= cent_mem[dist_idx_q];
	end

	always_ff @(posedge clk) begin
		if (adj_we)
			adj_mem[node_q] <= adj_wdata;
		adj_rd_q <= adj_mem[node_q];
	end

	always_ff @(posedge clk) begin
		if (dmg_we)
			dmg_mem[seed_q] <= sat_w;
		dmg_rd_q <= dmg_mem[seed_q];
	end

	always_ff @(posedge clk) begin
		if (q_we)
			q_mem[q_waddr] <= q_wdata;
		q_rd_q <= q_mem[head_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			anchor_q    <= '0;
			destroyed_q <= '0;
			visit_q     <= '0;
			dmg_v_q     <= '0;
			adj_v_q     <= '0;
			pend_v_q    <= 1'b0;
			valid       <= 1'b0;
			best_v_q    <= 1'b0;
			det_any_q   <= 1'b0;
			any_anch_q  <= 1'b0;
			c_q         <= '0;
			j_q         <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			dk_q        <= '0;
		end else begin
			valid <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						func_q    <= func;
						ni_q      <= neighbor_index;
						px_q      <= pos_x ^ {1'b1, {(COORD_BITS-1){1'b0}}};
						py_q      <= pos_y ^ {1'b1, {(COORD_BITS-1){1'b0}}};
						pz_q      <= pos_z ^ {1'b1, {(COORD_BITS-1){1'b0}}};
						amt_q     <= damage_amount;
						hit_rad_q <= damage_radius;
						case (func)
							FUNC_LOAD_CHUNK: anchor_q[chunk_index] <= anchored;
							FUNC_LOAD_EDGE: begin
								node_q  <= chunk_index;
								state_q <= ST_EWAIT;
							end
							FUNC_CHIP_HIT, FUNC_DIRECT_HIT: begin
								c_q      <= '0;
								best_v_q <= 1'b0;
								state_q  <= ST_NR;
							end
							FUNC_RESTORE: begin
								destroyed_q <= '0;
								dmg_v_q     <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_EWAIT: state_q <= ST_EWR;
				ST_EWR: begin
					adj_v_q[node_q] <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_DRD: begin
					dk_q    <= '0;
					state_q <= ST_DMUL;
				end
				ST_DMUL: begin
					dk_q <= dk_q + 2'd1;
					if (dk_q != 2'd3) begin
						prod_q <= prod_w;
						acc_q  <= (dk_q == 2'd0) ? '0 : acc_q + AW'(prod_q);
					end else begin
						acc_q   <= acc_q + AW'(prod_q);
						state_q <= ret_q;
					end
				end
				ST_NR: begin
					if (c_q == n_used) begin
						if (!best_v_q) begin
							pend_v_q     <= 1'b1;
							pend_kind_q  <= EV_NOTHING;
							pend_id_q    <= '0;
							pend_total_q <= '0;
							pend_seed_q  <= 1'b0;
							state_q      <= ST_FLUSH;
						end else if (func_q == FUNC_DIRECT_HIT) begin
							radius_q <= hit_rad_q;
							state_q  <= ST_R2;
						end else begin
							state_q <= ST_DMGW;
						end
					end else if (destroyed_q[c_q[IDX_W-1:0]]) begin
						c_q <= c_q + CNT_W'(1);
					end else begin
						dist_idx_q <= c_q[IDX_W-1:0];
						ret_q      <= ST_NRCMP;
						state_q    <= ST_DRD;
					end
				end
				ST_NRCMP: begin
					if (!best_v_q || acc_q < best_d_q) begin
						best_v_q <= 1'b1;
						best_d_q <= acc_q;
						seed_q   <= c_q[IDX_W-1:0];
					end
					c_q     <= c_q + CNT_W'(1);
					state_q <= ST_NR;
				end
				ST_DMGW: state_q <= ST_DMG;
				ST_DMG: begin
					if (sat_w >= thr_q) begin
						dmg_v_q[seed_q] <= 1'b0;
						radius_q        <= rad_cfg_q;
						state_q         <= ST_R2;
					end else begin
						dmg_v_q[seed_q] <= 1'b1;
						pend_v_q     <= 1'b1;
						pend_kind_q  <= EV_DAMAGE;
						pend_id_q    <= seed_q;
						pend_total_q <= sat_w;
						pend_seed_q  <= 1'b0;
						state_q      <= ST_FLUSH;
					end
				end
				ST_R2: begin
					r2_q      <= prod_w;
					visit_q   <= NUM_CHUNKS'(1) << seed_q;
					head_q    <= '0;
					tail_q    <= CNT_W'(1);
					det_any_q <= 1'b0;
					state_q   <= ST_B1;
				end
				ST_B1: state_q <= (head_q == tail_q) ? ST_BEND : ST_B2;
				ST_B2: begin
					node_q <= q_rd_q;
					head_q <= head_q + CNT_W'(1);
					if (anchor_q[q_rd_q]) begin
						state_q <= ST_B1;
					end else begin
						if (pend_v_q) begin
							valid        <= 1'b1;
							event_kind   <= pend_kind_q;
							chunk_id     <= pend_id_q;
							damage_total <= pend_total_q;
							is_seed      <= pend_seed_q;
							last         <= 1'b0;
						end
						pend_v_q     <= 1'b1;
						pend_kind_q  <= EV_DETACHED;
						pend_id_q    <= q_rd_q;
						pend_total_q <= '0;
						pend_seed_q  <= (q_rd_q == seed_q);
						destroyed_q[q_rd_q] <= 1'b1;
						dmg_v_q[q_rd_q]     <= 1'b0;
						det_any_q <= 1'b1;
						j_q       <= '0;
						state_q   <= ST_BROW;
					end
				end
				ST_BROW: state_q <= ST_B3;
				ST_B3: begin
					if (j_q == n_used) begin
						state_q <= ST_B1;
					end else if (cand) begin
						dist_idx_q <= j_q[IDX_W-1:0];
						ret_q      <= ST_B4;
						state_q    <= ST_DRD;
					end else begin
						j_q <= j_q + CNT_W'(1);
					end
				end
				ST_B4: begin
					if ((acc_q[AW-1:AW-2] == 2'b00) && (acc_q[AW-3:0] <= r2_q)) begin
						visit_q[j_q[IDX_W-1:0]] <= 1'b1;
						if (tail_q < CNT_W'(NUM_CHUNKS))
							tail_q <= tail_q + CNT_W'(1);
					end
					j_q     <= j_q + CNT_W'(1);
					state_q <= ST_B3;
				end
				ST_BEND: begin
					if (!det_any_q) begin
						pend_v_q     <= 1'b1;
						pend_kind_q  <= EV_NOTHING;
						pend_id_q    <= seed_q;
						pend_total_q <= '0;
						pend_seed_q  <= 1'b0;
						state_q      <= ST_FLUSH;
					end else begin
						visit_q    <= '0;
						head_q     <= '0;
						tail_q     <= '0;
						c_q        <= '0;
						any_anch_q <= 1'b0;
						state_q    <= ST_A1;
					end
				end
				ST_A1: begin
					if (c_q == n_used) begin
						state_q <= any_anch_q ? ST_S1 : ST_FLUSH;
					end else begin
						if (!destroyed_q[c_q[IDX_W-1:0]] && anchor_q[c_q[IDX_W-1:0]]) begin
							any_anch_q <= 1'b1;
							visit_q[c_q[IDX_W-1:0]] <= 1'b1;
							tail_q <= tail_q + CNT_W'(1);
						end
						c_q <= c_q + CNT_W'(1);
					end
				end
				ST_S1: begin
					if (head_q == tail_q) begin
						c_q     <= '0;
						state_q <= ST_CL;
					end else begin
						state_q <= ST_S2;
					end
				end
				ST_S2: begin
					node_q  <= q_rd_q;
					head_q  <= head_q + CNT_W'(1);
					j_q     <= '0;
					state_q <= ST_SROW;
				end
				ST_SROW: state_q <= ST_S3;
				ST_S3: begin
					if (j_q == n_used) begin
						state_q <= ST_S1;
					end else begin
						if (cand) begin
							visit_q[j_q[IDX_W-1:0]] <= 1'b1;
							if (tail_q < CNT_W'(NUM_CHUNKS))
								tail_q <= tail_q + CNT_W'(1);
						end
						j_q <= j_q + CNT_W'(1);
					end
				end
				ST_CL: begin
					if (c_q == n_used) begin
						state_q <= ST_FLUSH;
					end else begin
						if (!destroyed_q[c_q[IDX_W-1:0]] && !visit_q[c_q[IDX_W-1:0]]) begin
							if (pend_v_q) begin
								valid        <= 1'b1;
								event_kind   <= pend_kind_q;
								chunk_id     <= pend_id_q;
								damage_total <= pend_total_q;
								is_seed      <= pend_seed_q;
								last         <= 1'b0;
							end
							pend_v_q     <= 1'b1;
							pend_kind_q  <= EV_COLLAPSE;
							pend_id_q    <= c_q[IDX_W-1:0];
							pend_total_q <= '0;
							pend_seed_q  <= 1'b0;
							destroyed_q[c_q[IDX_W-1:0]] <= 1'b1;
							dmg_v_q[c_q[IDX_W-1:0]]     <= 1'b0;
						end
						c_q <= c_q + CNT_W'(1);
					end
				end
				ST_FLUSH: begin
					valid        <= 1'b1;
					event_kind   <= pend_kind_q;
					chunk_id     <= pend_id_q;
					damage_total <= pend_total_q;
					is_seed      <= pend_seed_q;
					last         <= 1'b1;
					pend_v_q     <= 1'b0;
					state_q      <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/fdc_checker.sv @@
// ----------------------------------------------------------------------------
// fdc_checker
// Port-level checks on command acceptance and the result beat sequence.
// ----------------------------------------------------------------------------
`include "fracture_detach_and_collapse_macros.svh"

module fdc_checker
	import fdc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] func,
	input logic       valid,
	input logic       last
);

	`FDC_CHECK(a_result_follows_work, valid |-> $past(busy))
	`FDC_CHECK(a_hit_goes_busy, (start && !busy && (func == FUNC_CHIP_HIT || func == FUNC_DIRECT_HIT)) |=> busy)
	`FDC_CHECK_MSG(a_last_ends_burst, (valid && last) |=> !valid, "fdc: beat after last")
	`FDC_CHECK_MSG(a_more_beats_busy, (valid && !last) |-> busy, "fdc: idle before last beat")
	`FDC_CHECK(a_load_single_cycle, (start && !busy && func == FUNC_LOAD_CHUNK) |=> !busy)

endmodule

bind fracture_detach_and_collapse fdc_checker u_fdc_checker (.*);

@@ sim/fracture_detach_and_collapse_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fracture_detach_and_collapse_tb
// Drives chunk loads, edge loads, chip hits, direct hits and restores into the
// block, and checks every result beat against an in-bench predictor of the
// hit search, damage accumulation, radius flood fill and anchor support walk.
// A short table of directed rows comes first, then random traffic over
// several register settings on a fully loaded chunk grid.
// ----------------------------------------------------------------------------
module fracture_detach_and_collapse_tb;
	import fdc_pkg::*;

	typedef struct packed {
		logic [2:0]  op;
		logic [5:0]  ci;
		logic [5:0]  ni;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic        anch;
		logic [15:0] dmg;
		logic [15:0] rad;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  id;
		logic [15:0] total;
		logic        seed;
		logic        fin;
	} event_t;

	typedef struct packed {
		cmd_t        c;
		logic        is_cfg;
		logic [1:0]  rsel;
		logic [15:0] val;
		logic        typed;
		event_t      r;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic [2:0] func = '0;
	logic [IDX_W-1:0] chunk_index = '0;
	logic [IDX_W-1:0] neighbor_index = '0;
	logic signed [COORD_BITS-1:0] pos_x = '0;
	logic signed [COORD_BITS-1:0] pos_y = '0;
	logic signed [COORD_BITS-1:0] pos_z = '0;
	logic anchored = 0;
	logic [VAL_W-1:0] damage_amount = '0;
	logic [VAL_W-1:0] damage_radius = '0;
	logic valid;
	logic [1:0] event_kind;
	logic [IDX_W-1:0] chunk_id;
	logic [VAL_W-1:0] damage_total;
	logic is_seed;
	logic last;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	fracture_detach_and_collapse dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	initial begin
		#100000000;
		$display("Regression FAIL");
		$finish;
	end

	// Predictor state
	logic [15:0] cx [64];
	logic [15:0] cy [64];
	logic [15:0] cz [64];
	logic        anchor_bit [64];
	logic [63:0] adj [64];
	logic [15:0] dmg_acc [64];
	logic        gone [64];
	logic [15:0] thresh_q;
	logic [15:0] radius_q;
	logic [6:0]  count_q;

	event_t pending [$];
	int errors = 0;
	bit calm = 0;

	task automatic report(string what, longint exp_v, longint got_v);
		$display("%0t mismatch %s: expected %0d got %0d", $time, what, exp_v, got_v);
		errors++;
	endtask

	function automatic int live_count();
		return (count_q > 64) ? 64 : int'(count_q);
	endfunction

	function automatic longint unsigned span_sq(int c, logic [15:0] px, logic [15:0] py,
			logic [15:0] pz);
		longint unsigned s, d;
		s = 0;
		d = (cx[c] >= px) ? cx[c] - px : px - cx[c];
		s += d * d;
		d = (cy[c] >= py) ? cy[c] - py : py - cy[c];
		s += d * d;
		d = (cz[c] >= pz) ? cz[c] - pz : pz - cz[c];
		s += d * d;
		return s;
	endfunction

	function automatic void fracture(int seed, logic [15:0] radius, logic [15:0] px,
			logic [15:0] py, logic [15:0] pz);
		event_t out [$];
		event_t e;
		int walk [$];
		bit seen [64];
		int n, id;
		bit any_anchor;
		longint unsigned r2;
		n = live_count();
		r2 = longint'(radius) * longint'(radius);
		any_anchor = 0;
		foreach (seen[j]) seen[j] = 0;
		walk.insert(walk.size(), seed);
		seen[seed] = 1;
		while (walk.size() > 0) begin
			id = walk.pop_front();
			if (anchor_bit[id]) continue;
			e = '{EV_DETACHED, id[5:0], 16'd0, id == seed, 1'b0};
			out.insert(out.size(), e);
			for (int j = 0; j < n; j++) begin
				if (!adj[id][j] || seen[j] || gone[j]) continue;
				if (span_sq(j, px, py, pz) > r2) continue;
				seen[j] = 1;
				walk.insert(walk.size(), j);
			end
		end
		if (out.size() == 0) begin
			e = '{EV_NOTHING, seed[5:0], 16'd0, 1'b0, 1'b1};
			pending.insert(pending.size(), e);
			return;
		end
		foreach (out[k]) begin
			gone[out[k].id] = 1;
			dmg_acc[out[k].id] = 0;
		end
		foreach (seen[j]) seen[j] = 0;
		for (int c = 0; c < n; c++) begin
			if (gone[c] || !anchor_bit[c]) continue;
			any_anchor = 1;
			seen[c] = 1;
			walk.insert(walk.size(), c);
		end
		if (any_anchor) begin
			while (walk.size() > 0) begin
				id = walk.pop_front();
				for (int j = 0; j < n; j++) begin
					if (!adj[id][j] || seen[j] || gone[j]) continue;
					seen[j] = 1;
					walk.insert(walk.size(), j);
				end
			end
			for (int c = 0; c < n; c++) begin
				if (gone[c] || seen[c]) continue;
				e = '{EV_COLLAPSE, c[5:0], 16'd0, 1'b0, 1'b0};
				if (out.size() < 64) out.insert(out.size(), e);
				gone[c] = 1;
				dmg_acc[c] = 0;
			end
		end
		out[out.size() - 1].fin = 1;
		foreach (out[k]) pending.insert(pending.size(), out[k]);
	endfunction

	function automatic void predict(cmd_t c);
		logic [15:0] px, py, pz;
		int seed, n;
		longint unsigned best, d;
		int unsigned t;
		event_t e;
		px = c.x ^ 16'h8000;
		py = c.y ^ 16'h8000;
		pz = c.z ^ 16'h8000;
		case (c.op)
			FUNC_LOAD_CHUNK: begin
				cx[c.ci] = px;
				cy[c.ci] = py;
				cz[c.ci] = pz;
				anchor_bit[c.ci] = c.anch;
			end
			FUNC_LOAD_EDGE: adj[c.ci][c.ni] = 1'b1;
			FUNC_CHIP_HIT, FUNC_DIRECT_HIT: begin
				seed = -1;
				best = 0;
				n = live_count();
				for (int k = 0; k < n; k++) begin
					if (gone[k]) continue;
					d = span_sq(k, px, py, pz);
					if (seed < 0 || d < best) begin
						seed = k;
						best = d;
					end
				end
				if (seed < 0) begin
					e = '{EV_NOTHING, 6'd0, 16'd0, 1'b0, 1'b1};
					pending.insert(pending.size(), e);
				end else if (c.op == FUNC_DIRECT_HIT) begin
					fracture(seed, c.rad, px, py, pz);
				end else begin
					t = dmg_acc[seed] + c.dmg;
					if (t > 32'hFFFF) t = 32'hFFFF;
					if (t >= thresh_q) begin
						dmg_acc[seed] = 0;
						fracture(seed, radius_q, px, py, pz);
					end else begin
						dmg_acc[seed] = t[15:0];
						e = '{EV_DAMAGE, seed[5:0], t[15:0], 1'b0, 1'b1};
						pending.insert(pending.size(), e);
					end
				end
			end
			FUNC_RESTORE: begin
				foreach (gone[k]) begin
					gone[k] = 0;
					dmg_acc[k] = 0;
				end
			end
			default: ;
		endcase
	endfunction

	always @(posedge clk) begin
		event_t e;
		if (arst_n && valid) begin
			if (pending.size() == 0) begin
				report("unexpected beat, chunk", -1, chunk_id);
			end else begin
				e = pending.pop_front();
				if (event_kind !== e.kind) report("event_kind", e.kind, event_kind);
				if (chunk_id !== e.id) report("chunk_id", e.id, chunk_id);
				if (damage_total !== e.total) report("damage_total", e.total, damage_total);
				if (is_seed !== e.seed) report("is_seed", e.seed, is_seed);
				if (last !== e.fin) report("last", e.fin, last);
			end
		end
	end

	task automatic issue(cmd_t c, bit typed = 0, event_t r = '0);
		int gap, before_n;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= c.op;
		chunk_index <= c.ci;
		neighbor_index <= c.ni;
		pos_x <= c.x;
		pos_y <= c.y;
		pos_z <= c.z;
		anchored <= c.anch;
		damage_amount <= c.dmg;
		damage_radius <= c.rad;
		@(posedge clk);
		while (busy) @(posedge clk);
		before_n = pending.size();
		predict(c);
		if (typed) begin
			while (pending.size() > before_n) void'(pending.pop_back());
			pending.insert(pending.size(), r);
		end
	endtask

	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending.size() != 0 || busy) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] rsel, logic [15:0] value);
		logic [31:0] mask;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {rsel, 2'b00};
		pwdata <= {16'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (rsel)
			REG_THRESHOLD: thresh_q = value;
			REG_RADIUS: radius_q = value;
			default: count_q = value[6:0];
		endcase
		mask = (rsel == REG_COUNT) ? 32'h7F : 32'hFFFF;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (value & mask)) report("register readback", value & mask,
			prdata & mask);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic cmd_t mk(logic [2:0] op, int ci, int ni, int x, int y, int z,
			logic anch, int dmg, int rad);
		cmd_t c;
		c = '{op, ci[5:0], ni[5:0], x[15:0], y[15:0], z[15:0], anch, dmg[15:0], rad[15:0]};
		return c;
	endfunction

	function automatic row_t act(cmd_t c);
		row_t r;
		r = '0;
		r.c = c;
		return r;
	endfunction

	function automatic row_t act_typed(cmd_t c, logic [1:0] kind, int id, int total);
		row_t r;
		r = act(c);
		r.typed = 1;
		r.r = '{kind, id[5:0], total[15:0], 1'b0, 1'b1};
		return r;
	endfunction

	function automatic row_t set_reg(logic [1:0] rsel, int value);
		row_t r;
		r = '0;
		r.is_cfg = 1;
		r.rsel = rsel;
		r.val = value[15:0];
		return r;
	endfunction

	function automatic cmd_t random_cmd();
		int r, k;
		cmd_t c;
		c = mk($urandom_range(0, 7), $urandom_range(0, 63), $urandom_range(0, 63),
			$urandom, $urandom, $urandom, $urandom_range(0, 1), $urandom, $urandom);
		r = $urandom_range(0, 99);
		k = $urandom_range(0, 63);
		if (r < 75) begin
			c.op = (r < 45) ? FUNC_CHIP_HIT : FUNC_DIRECT_HIT;
			if (r < 70) begin
				c.x = (cx[k] ^ 16'h8000) + $urandom_range(0, 200) - 100;
				c.y = (cy[k] ^ 16'h8000) + $urandom_range(0, 200) - 100;
				c.z = (cz[k] ^ 16'h8000) + $urandom_range(0, 200) - 100;
				if ($urandom_range(0, 3) != 0) c.dmg = $urandom_range(0, 20000);
				if ($urandom_range(0, 3) != 0) c.rad = $urandom_range(0, 900);
			end
		end else if (r < 82) begin
			c.op = FUNC_LOAD_CHUNK;
			c.x = (k % 4) * 256 + $urandom_range(0, 300) - 150;
			c.y = ((k / 4) % 4) * 256;
			c.z = (k / 16) * 256;
		end else if (r < 90) begin
			c.op = FUNC_LOAD_EDGE;
		end else if (r < 95) begin
			c.op = FUNC_RESTORE;
		end else begin
			c.op = 3'($urandom_range(5, 7));
		end
		return c;
	endfunction

	initial begin
		row_t rows [$];
		cmd_t c;
		int done;
		logic [15:0] phase_thr [4];
		logic [15:0] phase_rad [4];
		logic [15:0] phase_cnt [4];

		foreach (cx[k]) begin
			cx[k] = 0;
			cy[k] = 0;
			cz[k] = 0;
			anchor_bit[k] = 0;
			adj[k] = '0;
			dmg_acc[k] = 0;
			gone[k] = 0;
		end
		thresh_q = THRESHOLD_RESET;
		radius_q = RADIUS_RESET;
		count_q = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows.insert(rows.size(), act_typed(mk(FUNC_CHIP_HIT, 0, 0, 0, 0, 0, 0, 100, 0),
			EV_NOTHING, 0, 0));
		rows.insert(rows.size(), act_typed(mk(FUNC_DIRECT_HIT, 0, 0, 0, 0, 0, 0, 0, 65535),
			EV_NOTHING, 0, 0));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_CHUNK, 0, 0, 0, 0, 0, 1, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_CHUNK, 1, 0, 256, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_CHUNK, 2, 0, 512, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_CHUNK, 3, 0, -32768, -32768, -32768, 0,
			0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_CHUNK, 63, 0, 32767, 32767, 32767, 1,
			0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_EDGE, 0, 1, 0, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_EDGE, 1, 2, 0, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_EDGE, 1, 0, 0, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_EDGE, 2, 1, 0, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_LOAD_EDGE, 63, 63, 0, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), set_reg(REG_COUNT, 4));
		rows.insert(rows.size(), act_typed(mk(FUNC_CHIP_HIT, 0, 0, 256, 0, 0, 0, 100, 0),
			EV_DAMAGE, 1, 100));
		rows.insert(rows.size(), act(mk(FUNC_CHIP_HIT, 0, 0, 256, 0, 0, 0, 65535, 0)));
		rows.insert(rows.size(), act_typed(mk(FUNC_CHIP_HIT, 0, 0, 0, 0, 0, 0, 65535, 0),
			EV_NOTHING, 0, 0));
		rows.insert(rows.size(), act(mk(FUNC_RESTORE, 0, 0, 0, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_DIRECT_HIT, 0, 0, 512, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(FUNC_DIRECT_HIT, 0, 0, -32768, -32768, -32768, 0,
			0, 65535)));
		rows.insert(rows.size(), act(mk(FUNC_CHIP_HIT, 0, 0, 32767, 32767, 32767, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(3'd5, 63, 63, -1, -1, -1, 1, 65535, 65535)));
		rows.insert(rows.size(), act(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0)));
		rows.insert(rows.size(), act(mk(3'd7, 21, 42, 1, 2, 3, 1, 4, 5)));
		rows.insert(rows.size(), act(mk(FUNC_RESTORE, 0, 0, 0, 0, 0, 0, 0, 0)));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				settle();
				write_reg(rows[i].rsel, rows[i].val);
			end else begin
				issue(rows[i].c, rows[i].typed, rows[i].r);
			end
		end

		// Full 4x4x4 grid with the bottom row anchored; edges link the lowest layer only.
		for (int k = 0; k < 64; k++)
			issue(mk(FUNC_LOAD_CHUNK, k, 0, (k % 4) * 256, ((k / 4) % 4) * 256,
				(k / 16) * 256, k < 4, 0, 0));
		for (int k = 0; k < 16; k++) begin
			if (k % 4 != 3) begin
				issue(mk(FUNC_LOAD_EDGE, k, k + 1, 0, 0, 0, 0, 0, 0));
				issue(mk(FUNC_LOAD_EDGE, k + 1, k, 0, 0, 0, 0, 0, 0));
			end
			if (k < 12 && k % 4 == 0) begin
				issue(mk(FUNC_LOAD_EDGE, k, k + 4, 0, 0, 0, 0, 0, 0));
				issue(mk(FUNC_LOAD_EDGE, k + 4, k, 0, 0, 0, 0, 0, 0));
			end
		end

		phase_thr = '{16'd4000, 16'd0, 16'd65535, 16'($urandom)};
		phase_rad = '{16'd400, 16'd0, 16'd65535, 16'($urandom)};
		phase_cnt = '{16'd64, 16'd127, 16'd2, 16'($urandom_range(0, 127))};
		for (int ph = 0; ph < 4; ph++) begin
			settle();
			write_reg(REG_THRESHOLD, phase_thr[ph]);
			write_reg(REG_RADIUS, phase_rad[ph]);
			write_reg(REG_COUNT, phase_cnt[ph]);
			done = 0;
			while (done < 6) begin
				if ($urandom_range(0, 15) == 0) calm = !calm;
				c = random_cmd();
				issue(c);
				if (c.op <= FUNC_RESTORE) done++;
			end
		end

		settle();
		repeat (100) @(posedge clk);
		if (errors == 0 && pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
